// ----- hw/rtl/ufwb_pkg.sv -----
// ----------------------------------------------------------------------------
// ufwb_pkg - shared types and constants for the union-find wall breaker
// Item formats, store geometry, register indexes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ufwb_pkg;

  // Grid limits and store geometry
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W     = $clog2(CELLS);

  // Field widths
  localparam int COORD_W = 5;
  localparam int RAND_W  = 16;
  localparam int GRID_W  = 6;
  localparam int THR_W   = 17;
  localparam int RANK_W  = 4;
  localparam int PROD_W  = COORD_W + GRID_W;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_THRESHOLD = 2'd2;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [RANK_W-1:0] rank_t;

  // One wall to consider
  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               toward_south;
    logic [RAND_W-1:0]  random_value;
  } in_item_t;

  // Outcome for one wall
  typedef struct packed {
    logic open_wall;
    logic components_joined;
    logic bad_edge;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;     // clearing pass: write one entry of each store
    logic load_item;    // capture the incoming beat
    logic load_nodes;   // register both cell indices
    logic side;         // 0: first cell, 1: neighbour
    logic walk_start;   // walk pointer to the selected cell, read it
    logic walk_follow;  // walk pointer to the parent just read
    logic save_root;    // current node is the root
    logic compress_wr;  // point current node straight at the root
    logic save_root_a;  // keep root of the first cell
    logic rank_sel_b;   // rank read address: 0 first root, 1 second root
    logic save_rank_a;  // keep rank of the first root
    logic union_wr;     // link the two roots
    logic set_bad;
    logic set_loop;
    logic set_union;
    logic load_out;     // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic bad;
    logic found;
    logic at_root;
    logic same_root;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ufwb_datapath.sv -----
// ----------------------------------------------------------------------------
// ufwb_datapath - stores, walk registers and result register
// Holds the parent and rank memories, the configuration registers, the
// pointer-chasing registers and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufwb_datapath (
  input  wire                                clk,
  input  wire                                rst_n,
  input  ufwb_pkg::cmd_t                     cmd,
  output ufwb_pkg::status_t                  sts,
  input  ufwb_pkg::in_item_t                 in_data,
  output ufwb_pkg::out_item_t                out_data,
  input  wire                                cfg_we,
  input  wire [ufwb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [ufwb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ufwb_pkg::*;

  // Configuration registers
  logic [GRID_W-1:0] grid_width_r;
  logic [GRID_W-1:0] grid_height_r;
  logic [THR_W-1:0]  threshold_r;

  // Item and walk registers
  in_item_t  item_r;
  cell_t     node_a_r, node_b_r;
  cell_t     cur_r, root_r, root_a_r;
  rank_t     rank_a_r;
  cell_t     clr_r;
  out_item_t res_r;
  out_item_t out_data_r;

  // Stores
  cell_t parent_mem [CELLS];
  rank_t rank_mem   [CELLS];
  cell_t p_rdata_r;
  rank_t r_rdata_r;

  // Combinational
  logic [GRID_W-1:0] w, h, x1, y1, x2, y2;
  logic [PROD_W-1:0] lin_a, lin_b;
  cell_t             node_sel, p_raddr, p_waddr, p_wdata, r_raddr;
  logic              p_we, r_we;
  rank_t             r_wdata;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_W'(32);
      grid_height_r <= GRID_W'(32);
      threshold_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:     grid_width_r  <= cfg_data[GRID_W-1:0];
        CFG_GRID_HEIGHT:    grid_height_r <= cfg_data[GRID_W-1:0];
        CFG_LOOP_THRESHOLD: threshold_r   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid, neighbour and range check
  always_comb begin
    w  = (int'(grid_width_r) > MAX_WIDTH) ? GRID_W'(MAX_WIDTH) : grid_width_r;
    h  = (int'(grid_height_r) > MAX_HEIGHT) ? GRID_W'(MAX_HEIGHT) : grid_height_r;
    x1 = GRID_W'(item_r.cell_x);
    y1 = GRID_W'(item_r.cell_y);
    x2 = item_r.toward_south ? x1 : x1 + GRID_W'(1);
    y2 = item_r.toward_south ? y1 + GRID_W'(1) : y1;
    lin_a = PROD_W'(item_r.cell_y) * PROD_W'(w) + PROD_W'(item_r.cell_x);
    lin_b = lin_a + (item_r.toward_south ? PROD_W'(w) : PROD_W'(1));
  end

  assign sts.bad       = (x1 >= w) || (y1 >= h) || (x2 >= w) || (y2 >= h);
  assign sts.clr_last  = (clr_r == CELL_W'(CELLS - 1));
  assign sts.found     = (p_rdata_r == cur_r);
  assign sts.at_root   = (cur_r == root_r);
  assign sts.same_root = (root_a_r == root_r);

  // Item, nodes and walk pointer
  assign node_sel = cmd.side ? node_b_r : node_a_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item)   item_r   <= in_data;
    if (cmd.load_nodes) begin
      node_a_r <= CELL_W'(lin_a);
      node_b_r <= CELL_W'(lin_b);
    end
    if (cmd.walk_start)       cur_r <= node_sel;
    else if (cmd.walk_follow) cur_r <= p_rdata_r;
    if (cmd.save_root)   root_r   <= cur_r;
    if (cmd.save_root_a) root_a_r <= root_r;
    if (cmd.save_rank_a) rank_a_r <= r_rdata_r;
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n)            clr_r <= '0;
    else if (cmd.clear_wr) clr_r <= clr_r + CELL_W'(1);
  end

  // Store port selection
  always_comb begin
    p_raddr = cmd.walk_start ? node_sel : p_rdata_r;
    r_raddr = cmd.rank_sel_b ? root_r : root_a_r;
    p_we    = 1'b0;
    p_waddr = clr_r;
    p_wdata = clr_r;
    r_we    = 1'b0;
    r_wdata = '0;
    if (cmd.clear_wr) begin
      p_we = 1'b1;
      r_we = 1'b1;
    end else if (cmd.compress_wr) begin
      p_we    = 1'b1;
      p_waddr = cur_r;
      p_wdata = root_r;
    end else if (cmd.union_wr) begin
      p_we = 1'b1;
      if (rank_a_r < r_rdata_r) begin
        p_waddr = root_a_r;
        p_wdata = root_r;
      end else begin
        p_waddr = root_r;
        p_wdata = root_a_r;
        // equal ranks: the surviving root grows, saturating
        if (rank_a_r == r_rdata_r && rank_a_r != RANK_MAX) begin
          r_we    = 1'b1;
          p_waddr = root_r;
        end
      end
      r_wdata = rank_a_r + rank_t'(1);
    end
  end

  // Parent and rank memories, read data registered
  always_ff @(posedge clk) begin
    if (p_we) parent_mem[p_waddr] <= p_wdata;
    p_rdata_r <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) rank_mem[cmd.clear_wr ? clr_r : root_a_r] <= r_wdata;
    r_rdata_r <= rank_mem[r_raddr];
  end

  // Result and output payload
  always_ff @(posedge clk) begin
    if (cmd.set_bad) begin
      res_r <= '{open_wall: 1'b0, components_joined: 1'b0, bad_edge: 1'b1};
    end else if (cmd.set_loop) begin
      res_r <= '{open_wall: ({1'b0, item_r.random_value} < threshold_r),
                 components_joined: 1'b0, bad_edge: 1'b0};
    end else if (cmd.set_union) begin
      res_r <= '{open_wall: 1'b1, components_joined: 1'b1, bad_edge: 1'b0};
    end
    if (cmd.load_out) out_data_r <= res_r;
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ufwb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ufwb_ctrl - sequencer for the union-find wall breaker
// Runs the clearing pass, the two root searches with compression, the
// rank-based link and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ufwb_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire                out_stall,
  input  ufwb_pkg::status_t  sts,
  output ufwb_pkg::cmd_t     cmd
);
  import ufwb_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_LAUNCH = 4'd3;
  localparam logic [3:0] S_FIND   = 4'd4;
  localparam logic [3:0] S_COMP   = 4'd5;
  localparam logic [3:0] S_RANK_A = 4'd6;
  localparam logic [3:0] S_RANK_B = 4'd7;
  localparam logic [3:0] S_UNION  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       side_r, side_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.side  = side_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          cmd.set_bad = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.load_nodes = 1'b1;
          side_nxt       = 1'b0;
          state_nxt      = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        cmd.walk_start = 1'b1;
        state_nxt      = S_FIND;
      end
      // chase parents until a node points at itself, then restart for compression
      S_FIND: begin
        if (sts.found) begin
          cmd.save_root  = 1'b1;
          cmd.walk_start = 1'b1;
          state_nxt      = S_COMP;
        end else begin
          cmd.walk_follow = 1'b1;
        end
      end
      // rewrite every node on the path to point at the root
      S_COMP: begin
        if (sts.at_root) begin
          if (!side_r) begin
            cmd.save_root_a = 1'b1;
            side_nxt        = 1'b1;
            state_nxt       = S_LAUNCH;
          end else begin
            state_nxt = S_RANK_A;
          end
        end else begin
          cmd.compress_wr = 1'b1;
          cmd.walk_follow = 1'b1;
        end
      end
      S_RANK_A: begin
        if (sts.same_root) begin
          cmd.set_loop = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_RANK_B;
        end
      end
      S_RANK_B: begin
        cmd.save_rank_a = 1'b1;
        cmd.rank_sel_b  = 1'b1;
        state_nxt       = S_UNION;
      end
      S_UNION: begin
        cmd.union_wr  = 1'b1;
        cmd.set_union = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Output beat valid
  always_comb begin
    priority if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/union_find_wall_breaker.sv -----
// ----------------------------------------------------------------------------
// union_find_wall_breaker - Kruskal maze step over a disjoint-set forest
// Takes one interior wall per input beat, finds both cell roots with path
// compression, links them by rank and reports whether the wall opens.
//
// Input channel (in_*): one wall per beat. Output channel (out_*): one result
// beat per input beat, in order. Config channel (cfg_*): index 0 grid width,
// 1 grid height, 2 loop threshold; always ready, write only while idle.
// One item at a time: the next beat is taken once the result of the last
// one is in the output register. Bad walls skip the root searches and walls
// inside one set skip the link. The parent store gives one pointer read per
// cycle on the search and on the rewrite.
// After reset a clearing pass writes all 1024 entries, loading the parent
// store with identity and the rank store with zero; in_stall stays high
// meanwhile.
// A finished result sits in the output register; while out_stall holds it
// the next wall is still accepted and processed, and waits at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_wall_breaker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  ufwb_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output ufwb_pkg::out_item_t              out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [ufwb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [ufwb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ufwb_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  ufwb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ufwb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ufwb_checker.sv -----
// ----------------------------------------------------------------------------
// ufwb_checker - port-level checks for the union-find wall breaker
// Watches the top-level ports and flags inconsistent result beats and
// handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

module ufwb_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input ufwb_pkg::out_item_t  out_data
);
  import ufwb_pkg::*;

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // one item at a time: busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  // a bad wall neither opens nor joins
  a_bad_is_inert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_edge |-> !out_data.open_wall && !out_data.components_joined)
    else $error("bad wall reported as open or joined");

  // joining always opens the wall
  a_join_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.components_joined |-> out_data.open_wall)
    else $error("join without opening");

endmodule

bind union_find_wall_breaker ufwb_checker u_ufwb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- tb/union_find_wall_breaker_tb.sv -----
// ----------------------------------------------------------------------------
// union_find_wall_breaker_tb - self-checking bench for the maze wall breaker
// Feeds interior walls through the in_ channel, keeps its own disjoint-set
// forest in step with the block and checks every out_ beat against it.
// Directed walls cover the grid corners, the loop threshold limits and the
// grid register corner cases. Shuffled Kruskal wall lists and random walls
// then run over several grid settings. Bursty input and a random output
// stall pattern load the handshakes, except in the first two maze runs.
// ----------------------------------------------------------------------------
module union_find_wall_breaker_tb;
  import ufwb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // Index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Mirror of the block's forest and registers
  cell_t              forest_parent [CELLS];
  rank_t              forest_rank [CELLS];
  logic [GRID_W-1:0]  grid_cols;
  logic [GRID_W-1:0]  grid_rows;
  logic [THR_W-1:0]   loop_thr;

  out_item_t pending_results [$];
  out_item_t want;

  int mismatches    = 0;
  int walls_sent    = 0;
  int results_seen  = 0;
  int joins_seen    = 0;
  int loops_opened  = 0;
  int bad_walls     = 0;
  int cycle_count   = 0;
  int burst_left    = 0;
  int stall_hold    = 0;
  bit stall_on      = 1'b0;
  bit rx_quiet      = 1'b0;
  bit tx_quiet      = 1'b0;

  union_find_wall_breaker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("union_find_wall_breaker verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // Root search with full path compression
  function automatic cell_t root_of(cell_t node);
    cell_t top;
    cell_t walk;
    cell_t nxt;
    int    k;
    top = node;
    for (k = 0; k < CELLS && forest_parent[top] != top; k++)
      top = forest_parent[top];
    walk = node;
    for (k = 0; k < CELLS && walk != top; k++) begin
      nxt = forest_parent[walk];
      forest_parent[walk] = top;
      walk = nxt;
    end
    return top;
  endfunction

  // Outcome of one wall; updates the forest as the block should
  function automatic out_item_t break_wall(in_item_t wall);
    out_item_t res;
    int        cols, rows, x, y, x2, y2, a, b;
    cell_t     ra, rb;
    res  = '0;
    cols = (grid_cols > MAX_WIDTH) ? MAX_WIDTH : int'(grid_cols);
    rows = (grid_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_rows);
    x    = int'(wall.cell_x);
    y    = int'(wall.cell_y);
    x2   = wall.toward_south ? x : x + 1;
    y2   = wall.toward_south ? y + 1 : y;
    a    = y * cols + x;
    b    = y2 * cols + x2;
    if (x >= cols || y >= rows || x2 >= cols || y2 >= rows || a >= CELLS || b >= CELLS) begin
      res.bad_edge = 1'b1;
      return res;
    end
    ra = root_of(cell_t'(a));
    rb = root_of(cell_t'(b));
    if (ra != rb) begin
      // union by rank, saturating
      if (forest_rank[ra] < forest_rank[rb]) begin
        forest_parent[ra] = rb;
      end else if (forest_rank[ra] > forest_rank[rb]) begin
        forest_parent[rb] = ra;
      end else begin
        forest_parent[rb] = ra;
        if (forest_rank[ra] < RANK_MAX) forest_rank[ra] = forest_rank[ra] + 1'b1;
      end
      res.open_wall         = 1'b1;
      res.components_joined = 1'b1;
    end else if (int'(wall.random_value) < int'(loop_thr)) begin
      res.open_wall = 1'b1;
    end
    return res;
  endfunction

  function automatic in_item_t make_wall(int x, int y, bit south, int rnd);
    in_item_t w;
    w.cell_x       = x[COORD_W-1:0];
    w.cell_y       = y[COORD_W-1:0];
    w.toward_south = south;
    w.random_value = rnd[RAND_W-1:0];
    return w;
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic check_field(string name, logic exp_v, logic got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %b, got %b", $time, name, exp_v, got_v);
    end
  endtask

  // Output stall pattern: alternating stall and free runs of random length
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_on   = !stall_on;
      stall_hold = stall_on ? $urandom_range(0, 6) : $urandom_range(0, 30);
    end
    out_stall <= stall_on && !rx_quiet;
  end

  // Result beats against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat %b with no wall outstanding", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("open_wall", want.open_wall, out_data.open_wall);
        check_field("components_joined", want.components_joined, out_data.components_joined);
        check_field("bad_edge", want.bad_edge, out_data.bad_edge);
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  // One wall beat, in bursts with random gaps
  task automatic send_wall(in_item_t wall);
    int        gap;
    out_item_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = tx_quiet ? 1000 : $urandom_range(1, 16);
      if (!tx_quiet)
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= wall;
    do @(posedge clk); while (in_stall);
    res = break_wall(wall);
    pending_results.push_back(res);
    walls_sent++;
    burst_left--;
    if (res.bad_edge) bad_walls++;
    else if (res.components_joined) joins_seen++;
    else if (res.open_wall) loops_opened++;
  endtask

  // Let every outstanding result come back, input held idle
  task automatic drain_results();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRID_WIDTH:     grid_cols = value[GRID_W-1:0];
      CFG_GRID_HEIGHT:    grid_rows = value[GRID_W-1:0];
      CFG_LOOP_THRESHOLD: loop_thr  = value[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(int cols, int rows, int thr);
    drain_results();
    cfg_write(CFG_GRID_WIDTH, cols);
    cfg_write(CFG_GRID_HEIGHT, rows);
    cfg_write(CFG_LOOP_THRESHOLD, thr);
  endtask

  // -------------------------------------------------------------------- tests

  // Reset grid: corners, off-grid neighbours, a redundant wall
  task automatic test_reset_grid();
    send_wall(make_wall(0, 0, 1'b0, 0));
    send_wall(make_wall(30, 31, 1'b0, 16'hFFFF));
    send_wall(make_wall(31, 30, 1'b1, 16'hFFFF));
    send_wall(make_wall(31, 31, 1'b0, 0));
    send_wall(make_wall(31, 31, 1'b1, 0));
    send_wall(make_wall(1, 0, 1'b1, 0));
    send_wall(make_wall(0, 0, 1'b0, 0));
    send_wall(make_wall(0, 0, 1'b1, 16'h5A5A));
    send_wall(make_wall(0, 1, 1'b0, 0));
  endtask

  // Loop threshold edges, wall (0,1) east already inside one set
  task automatic test_loop_threshold();
    drain_results();
    cfg_write(CFG_LOOP_THRESHOLD, 1);
    send_wall(make_wall(0, 1, 1'b0, 0));
    send_wall(make_wall(0, 1, 1'b0, 1));
    drain_results();
    cfg_write(CFG_LOOP_THRESHOLD, 65535);
    send_wall(make_wall(0, 1, 1'b0, 16'hFFFE));
    send_wall(make_wall(0, 1, 1'b0, 16'hFFFF));
    drain_results();
    cfg_write(CFG_LOOP_THRESHOLD, 65536);
    send_wall(make_wall(0, 1, 1'b0, 16'hFFFF));
    drain_results();
    cfg_write(CFG_LOOP_THRESHOLD, 17'h1FFFF);
    send_wall(make_wall(0, 1, 1'b0, 16'hFFFF));
  endtask

  // Zero, oversized and masked grid registers, spare index
  task automatic test_grid_registers();
    drain_results();
    cfg_write(CFG_GRID_WIDTH, 0);
    send_wall(make_wall(0, 0, 1'b1, 0));
    drain_results();
    cfg_write(CFG_GRID_WIDTH, 63);
    cfg_write(CFG_GRID_HEIGHT, 1);
    send_wall(make_wall(30, 0, 1'b0, 0));
    send_wall(make_wall(0, 0, 1'b1, 0));
    drain_results();
    // upper data bits must not reach the 6-bit register
    cfg_write(CFG_GRID_WIDTH, 17'h1FFC1);
    cfg_write(CFG_GRID_HEIGHT, 63);
    send_wall(make_wall(0, 0, 1'b1, 0));
    send_wall(make_wall(0, 0, 1'b0, 0));
    send_wall(make_wall(0, 31, 1'b1, 0));
    send_wall(make_wall(0, 30, 1'b1, 0));
    drain_results();
    cfg_write(CFG_GRID_HEIGHT, 0);
    cfg_write(CFG_SPARE_IDX, 17'h0001F);
    send_wall(make_wall(0, 0, 1'b1, 0));
  endtask

  // Every interior wall of the grid once, shuffled, with stray walls mixed in
  task automatic run_maze(int cols, int rows);
    in_item_t walls [$];
    in_item_t tmp;
    int       i, j, x, y;
    for (y = 0; y < rows; y++)
      for (x = 0; x < cols; x++) begin
        if (x + 1 < cols) walls.push_back(make_wall(x, y, 1'b0, $urandom_range(0, 65535)));
        if (y + 1 < rows) walls.push_back(make_wall(x, y, 1'b1, $urandom_range(0, 65535)));
      end
    for (i = walls.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = walls[i];
      walls[i] = walls[j];
      walls[j] = tmp;
    end
    foreach (walls[k]) begin
      if ($urandom_range(0, 9) == 0) send_wall(in_item_t'($urandom));
      send_wall(walls[k]);
    end
  endtask

  // Random walls: mostly inside the effective grid, some anywhere
  task automatic run_random_walls(int count);
    int cols, rows, n;
    bit south;
    cols = (grid_cols > MAX_WIDTH) ? MAX_WIDTH : int'(grid_cols);
    rows = (grid_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_rows);
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0 || (cols < 2 && rows < 2)) begin
        send_wall(in_item_t'($urandom));
      end else begin
        south = $urandom_range(0, 1);
        if (cols < 2) south = 1'b1;
        if (rows < 2) south = 1'b0;
        send_wall(make_wall($urandom_range(0, cols - (south ? 1 : 2)),
                            $urandom_range(0, rows - (south ? 2 : 1)),
                            south, $urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic test_random_mazes();
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    set_grid(8, 8, 17'h04000);
    run_maze(8, 8);
    set_grid(5, 3, 17'h1FFFF);
    run_maze(5, 3);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    set_grid(16, 16, $urandom_range(0, 65536));
    run_maze(16, 16);
    set_grid(1, 32, 65536);
    run_maze(1, 32);
    set_grid(32, 1, 0);
    run_maze(32, 1);
  endtask

  task automatic test_random_walls();
    set_grid(32, 32, $urandom_range(0, 65536));
    run_random_walls(250);
    // resize over the old forest
    set_grid(12, 9, $urandom_range(0, 65535));
    run_random_walls(60);
    set_grid(63, 40, $urandom_range(0, 17'h1FFFF));
    run_random_walls(100);
    set_grid(0, 20, 32768);
    run_random_walls(15);
    set_grid(20, 0, 32768);
    run_random_walls(10);
  endtask

  // --------------------------------------------------------------------- main
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int k = 0; k < CELLS; k++) begin
      forest_parent[k] = cell_t'(k);
      forest_rank[k]   = '0;
    end
    grid_cols = GRID_W'(MAX_WIDTH);
    grid_rows = GRID_W'(MAX_HEIGHT);
    loop_thr  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_grid();
    test_loop_threshold();
    test_grid_registers();
    test_random_mazes();
    test_random_walls();

    drain_results();
    repeat (64) @(posedge clk);
    $display("%0d walls, %0d results: %0d joins, %0d redundant walls opened, %0d off-grid",
             walls_sent, results_seen, joins_seen, loops_opened, bad_walls);
    $display("grids from 0 to clamped 63 wide and high, thresholds 0 to 0x1FFFF");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("union_find_wall_breaker verification clean");
    end else begin
      $display("union_find_wall_breaker verification failed");
    end
    $finish;
  end

endmodule
